### src/double_ended_ring_queue_core_macros.svh
// Assertion macros for the double-ended ring queue core.
`ifndef DOUBLE_ENDED_RING_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_RING_QUEUE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DERQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DERQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/derq_pkg.sv
// Package with the constants, types and helper function of the ring queue core.
`timescale 1ns / 1ps
`default_nettype none

package derq_pkg;

    localparam int DEPTH      = 16;
    localparam int ITEM_WIDTH = 64;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_PUSH_BACK  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_OVERWRITE  = 2'd2,
        MODE_POP        = 2'd3
    } t_mode;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_POP  = 1'b1
    } t_state;

    // A written length of zero acts as one, and one above the depth acts as the depth.
    function automatic logic [CNT_W-1:0] eff_len(input logic [4:0] value);
        logic [CNT_W-1:0] len;
        if (value == 5'd0) begin
            len = CNT_W'(1);
        end else if (32'(value) > DEPTH) begin
            len = CNT_W'(DEPTH);
        end else begin
            len = CNT_W'(value);
        end
        return len;
    endfunction

endpackage

`default_nettype wire

### src/double_ended_ring_queue_core.sv
// Top level of the double-ended ring queue core: control, pointers and entry memory.
`timescale 1ns / 1ps
`default_nettype none

// Double-ended ring queue with push to back, push to front, overwrite at front and pop.
//
// Command channel: an operation (i_mode, i_item_data) is transferred at a rising
// edge where start is high and busy is low. Every operation gives exactly one
// result on o_accepted, o_read_data and o_fill_count, shown for a single cycle
// with o_result_valid high. The receiver cannot stall, so each result must be
// taken in that cycle.
// Pushes, overwrites and pops on an empty queue need no memory read: the result
// appears in the cycle after the transfer and busy stays low, so such operations
// may follow one another every cycle.
// A successful pop reads the entry memory, whose read port is registered; busy
// is high in ST_POP while the entry arrives, the entry is cleared to zero at
// the end of ST_POP and the result is registered at that edge. No new operation
// is taken while a pop waits for its entry from the memory.
// Configuration: the length register is transferred on i_cfg_valid/o_cfg_ready
// while the core is idle and start is low; it empties the queue (pointers and
// count) but leaves stored entries as they are.
// Reset (synchronous, active low) restores the full length, empties the queue
// and drops any pending result; the entry memory is not cleared.
module double_ended_ring_queue_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_mode,
    input  wire logic [63:0] i_item_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [4:0]  i_cfg_data,
    output logic             o_result_valid,
    output logic             o_accepted,
    output logic [63:0]      o_read_data,
    output logic [4:0]       o_fill_count
);

    // Control state.
    derq_pkg::t_state               r_state, n_state;
    logic [derq_pkg::CNT_W-1:0]     r_len, n_len;
    logic [derq_pkg::CNT_W-1:0]     r_count, n_count;
    logic [derq_pkg::ADDR_W-1:0]    r_wr, n_wr;
    logic [derq_pkg::ADDR_W-1:0]    r_rd, n_rd;
    logic                           r_res_valid, n_res_valid;

    // Result payload.
    logic                           r_accepted, n_accepted;
    logic [63:0]                    r_read_data, n_read_data;
    logic [derq_pkg::CNT_W-1:0]     r_fill, n_fill;

    // Entry memory and its access controls.
    logic [derq_pkg::ITEM_WIDTH-1:0] r_mem [derq_pkg::DEPTH];
    logic [derq_pkg::ITEM_WIDTH-1:0] r_mem_q;
    logic                            mem_we;
    logic [derq_pkg::ADDR_W-1:0]     mem_waddr;
    logic [derq_pkg::ITEM_WIDTH-1:0] mem_wdata;
    logic                            mem_re;
    logic [derq_pkg::ADDR_W-1:0]     mem_raddr;

    logic                            take;
    logic                            cfg_take;
    logic [derq_pkg::ADDR_W-1:0]     last_slot;
    logic [derq_pkg::ADDR_W-1:0]     rd_inc;
    logic [derq_pkg::ADDR_W-1:0]     rd_dec;
    logic [derq_pkg::ADDR_W-1:0]     wr_inc;
    logic                            full;
    derq_pkg::t_mode                 mode;

    assign busy           = (r_state == derq_pkg::ST_POP);
    // An offered operation takes precedence, so a configuration write never
    // shares an edge with an operation transfer.
    assign o_cfg_ready    = (r_state == derq_pkg::ST_IDLE) && !start;
    assign take           = start && !busy;
    assign cfg_take       = i_cfg_valid && o_cfg_ready;
    assign mode           = derq_pkg::t_mode'(i_mode);

    // Ring arithmetic over the length in use.
    assign last_slot = derq_pkg::ADDR_W'(r_len - 1'b1);
    assign rd_inc    = (r_rd == last_slot) ? '0 : r_rd + 1'b1;
    assign rd_dec    = (r_rd == '0) ? last_slot : r_rd - 1'b1;
    assign wr_inc    = (r_wr == last_slot) ? '0 : r_wr + 1'b1;
    assign full      = (r_count == r_len);

    assign o_result_valid = r_res_valid;
    assign o_accepted     = r_accepted;
    assign o_read_data    = r_read_data;
    assign o_fill_count   = 5'(r_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= derq_pkg::ST_IDLE;
            r_len       <= derq_pkg::CNT_W'(derq_pkg::DEPTH);
            r_count     <= '0;
            r_wr        <= '0;
            r_rd        <= derq_pkg::ADDR_W'(derq_pkg::DEPTH - 1);
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_count     <= n_count;
            r_wr        <= n_wr;
            r_rd        <= n_rd;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_accepted  <= n_accepted;
        r_read_data <= n_read_data;
        r_fill      <= n_fill;
    end

    // Single write port, single registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_raddr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_count     = r_count;
        n_wr        = r_wr;
        n_rd        = r_rd;
        n_res_valid = 1'b0;
        n_accepted  = 1'b0;
        n_read_data = '0;
        n_fill      = r_count;
        mem_we      = 1'b0;
        mem_waddr   = r_wr;
        mem_wdata   = i_item_data[derq_pkg::ITEM_WIDTH-1:0];
        mem_re      = 1'b0;
        mem_raddr   = rd_inc;

        case (r_state)
            derq_pkg::ST_IDLE: begin
                if (cfg_take) begin
                    n_len   = derq_pkg::eff_len(i_cfg_data);
                    n_wr    = '0;
                    n_rd    = derq_pkg::ADDR_W'(derq_pkg::eff_len(i_cfg_data) - 1'b1);
                    n_count = '0;
                end else if (take) begin
                    case (mode)
                        derq_pkg::MODE_POP: begin
                            if (r_count != '0) begin
                                // Fetch the front entry; the result follows once it arrives.
                                mem_re  = 1'b1;
                                n_rd    = rd_inc;
                                n_count = r_count - 1'b1;
                                n_state = derq_pkg::ST_POP;
                            end else begin
                                n_res_valid = 1'b1;
                            end
                        end
                        derq_pkg::MODE_PUSH_BACK: begin
                            n_res_valid = 1'b1;
                            if (!full) begin
                                mem_we     = 1'b1;
                                mem_waddr  = r_wr;
                                n_wr       = wr_inc;
                                n_count    = r_count + 1'b1;
                                n_accepted = 1'b1;
                                n_fill     = r_count + 1'b1;
                            end
                        end
                        derq_pkg::MODE_PUSH_FRONT,
                        derq_pkg::MODE_OVERWRITE: begin
                            n_res_valid = 1'b1;
                            if (!full || mode == derq_pkg::MODE_OVERWRITE) begin
                                mem_we     = 1'b1;
                                mem_waddr  = r_rd;
                                n_rd       = rd_dec;
                                n_accepted = 1'b1;
                                // An overwrite keeps a nonzero count.
                                if (mode == derq_pkg::MODE_OVERWRITE && r_count != '0) begin
                                    n_count = r_count;
                                end else begin
                                    n_count = r_count + 1'b1;
                                end
                                n_fill = n_count;
                            end
                        end
                        default: begin
                            n_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            derq_pkg::ST_POP: begin
                // The popped slot is now r_rd; clear it and present the entry.
                mem_we      = 1'b1;
                mem_waddr   = r_rd;
                mem_wdata   = '0;
                n_res_valid = 1'b1;
                n_accepted  = 1'b1;
                n_read_data = 64'(r_mem_q);
                n_fill      = r_count;
                n_state     = derq_pkg::ST_IDLE;
            end
            default: begin
                n_state = derq_pkg::ST_IDLE;
            end
        endcase
    end

`include "double_ended_ring_queue_core_macros.svh"

    `DERQ_ASSERT_SAME(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= r_len,
        "count exceeds length")
    `DERQ_ASSERT_NEXT(a_pop_goes_busy, i_clk, i_rst_n,
        take && !cfg_take && mode == derq_pkg::MODE_POP && r_count != '0,
        busy && !o_result_valid, "pop did not wait for memory")
    `DERQ_ASSERT_NEXT(a_pop_result, i_clk, i_rst_n, busy,
        !busy && o_result_valid && o_accepted, "pop result missing")
    `DERQ_ASSERT_NEXT(a_push_result, i_clk, i_rst_n,
        take && !cfg_take && mode != derq_pkg::MODE_POP,
        o_result_valid && o_read_data == 64'd0, "push result missing")

endmodule

`default_nettype wire
